/* src/gbf_pkg.sv */
// Shared types, constants and helpers for the gaussian blur filter.
// Standalone package; no dependencies.
`default_nettype none

package gbf_pkg;

  localparam int unsigned PixW    = 8;
  localparam int unsigned PosW    = 10;
  localparam int unsigned DimW    = 11;
  localparam int unsigned WeightW = 16;
  localparam int unsigned NumWeights = 6;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned ProdW   = PixW + WeightW;
  localparam int unsigned OutTdataW = 32;

  // largest row/column count the position counters can express
  localparam logic [DimW-1:0] CountLimit = 11'd1024;

  typedef logic [PixW-1:0]    pixel_t;
  typedef logic [PosW-1:0]    pos_t;
  typedef logic [DimW-1:0]    dim_t;
  typedef logic [WeightW-1:0] weight_t;
  typedef weight_t [NumWeights-1:0] weights_t;

  typedef enum logic [CfgAddrW-1:0] {
    CfgImageWidth  = 3'd0,
    CfgImageHeight = 3'd1,
    CfgWeightD0    = 3'd2,
    CfgWeightD1    = 3'd3,
    CfgWeightD2    = 3'd4,
    CfgWeightD4    = 3'd5,
    CfgWeightD5    = 3'd6,
    CfgWeightD8    = 3'd7
  } cfg_reg_e;

  // slots in the weight table, by squared distance
  localparam int unsigned WSlotD0 = 0;
  localparam int unsigned WSlotD1 = 1;
  localparam int unsigned WSlotD2 = 2;
  localparam int unsigned WSlotD4 = 3;
  localparam int unsigned WSlotD5 = 4;
  localparam int unsigned WSlotD8 = 5;

  localparam dim_t    ResetWidth  = 11'd640;
  localparam dim_t    ResetHeight = 11'd480;
  localparam weight_t ResetWD0    = 16'd13380;
  localparam weight_t ResetWD1    = 16'd8116;
  localparam weight_t ResetWD2    = 16'd4922;

  // Weight of the tap at offset (dy, dx) from the window centre.
  function automatic weight_t tap_weight(input int dy, input int dx, input weights_t w);
    int d;
    d = dy * dy + dx * dx;
    case (d)
      0:       tap_weight = w[WSlotD0];
      1:       tap_weight = w[WSlotD1];
      2:       tap_weight = w[WSlotD2];
      4:       tap_weight = w[WSlotD4];
      5:       tap_weight = w[WSlotD5];
      8:       tap_weight = w[WSlotD8];
      default: tap_weight = '0;
    endcase
  endfunction

endpackage

`default_nettype wire

/* src/gaussian_blur_filter.sv */
// Gaussian blur over a raster pixel stream: line stores, window and weighted sum.
// Depends on gbf_pkg.
`default_nettype none

// Gaussian blur filter. Pixels arrive in raster order on the slave stream, one
// transaction per pixel, tuser marking the first pixel of a frame. Once a full
// (2R+1)x(2R+1) window is present, the block emits the weighted sum for the
// window centre together with its row and column; border pixels produce no
// output transaction. Weights are unsigned Q0.16 values, one per squared
// distance from the centre; the exact sum is shifted right by 16 once and
// saturated at 255. Throughput is one pixel per clock while the output is not
// stalled. There are two register stages: the accepting edge registers the
// pixel and reads the line stores, the edge on which the pixel leaves stage 1
// updates the window and loads the multiply-add result into the output
// register and raises m_axis_tvalid for a result-producing pixel.
// While a result waits for m_axis_tready, a further result-producing pixel is
// held in stage 1 and s_axis_tready is low. The line stores are 2R memories of
// MAX_WIDTH bytes with one read and one write port, each used once per pixel;
// a write and a read of the same column at one edge (frame restart) are
// forwarded. Line store contents are not cleared at reset; stale contents read
// in the first rows of a frame never reach an output transaction.
// Configuration writes are accepted on every cycle and must only be issued
// while the pipeline is empty.
module gaussian_blur_filter #(
  parameter int unsigned KERNEL_RADIUS = 1,   // 1 or 2
  parameter int unsigned MAX_WIDTH     = 1024 // line store depth, 8 to 4096
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,

  // pixel input
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,  // [7:0] pixel
  input  wire logic [0:0] s_axis_tuser,  // [0] frame_start

  // filtered output
  output logic        m_axis_tvalid,
  input  wire logic   m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [7:0] blurred, [17:8] out_row, [27:18] out_col
  output logic        m_axis_tlast,  // last interior pixel of the frame

  // register writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_addr_i,
  input  wire logic [15:0] cfg_data_i
);

  localparam int unsigned Side    = 2 * KERNEL_RADIUS + 1;
  localparam int unsigned NLines  = 2 * KERNEL_RADIUS;
  localparam int unsigned NTaps   = Side * Side;
  localparam int unsigned AddrW   = $clog2(MAX_WIDTH);
  localparam int unsigned WMax    = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
  localparam int unsigned SumW    = gbf_pkg::ProdW + $clog2(NTaps);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  gbf_pkg::dim_t     image_width_q, image_height_q;
  gbf_pkg::weights_t weights_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= gbf_pkg::ResetWidth;
      image_height_q <= gbf_pkg::ResetHeight;
      weights_q[gbf_pkg::WSlotD0] <= gbf_pkg::ResetWD0;
      weights_q[gbf_pkg::WSlotD1] <= gbf_pkg::ResetWD1;
      weights_q[gbf_pkg::WSlotD2] <= gbf_pkg::ResetWD2;
      weights_q[gbf_pkg::WSlotD4] <= '0;
      weights_q[gbf_pkg::WSlotD5] <= '0;
      weights_q[gbf_pkg::WSlotD8] <= '0;
    end else if (cfg_valid_i) begin
      unique case (gbf_pkg::cfg_reg_e'(cfg_addr_i))
        gbf_pkg::CfgImageWidth:  image_width_q  <= cfg_data_i[gbf_pkg::DimW-1:0];
        gbf_pkg::CfgImageHeight: image_height_q <= cfg_data_i[gbf_pkg::DimW-1:0];
        gbf_pkg::CfgWeightD0:    weights_q[gbf_pkg::WSlotD0] <= cfg_data_i;
        gbf_pkg::CfgWeightD1:    weights_q[gbf_pkg::WSlotD1] <= cfg_data_i;
        gbf_pkg::CfgWeightD2:    weights_q[gbf_pkg::WSlotD2] <= cfg_data_i;
        gbf_pkg::CfgWeightD4:    weights_q[gbf_pkg::WSlotD4] <= cfg_data_i;
        gbf_pkg::CfgWeightD5:    weights_q[gbf_pkg::WSlotD5] <= cfg_data_i;
        gbf_pkg::CfgWeightD8:    weights_q[gbf_pkg::WSlotD8] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective frame size, clamped to what the window and line stores support
  gbf_pkg::dim_t eff_width, eff_height;

  always_comb begin
    if (image_width_q < gbf_pkg::DimW'(Side)) begin
      eff_width = gbf_pkg::DimW'(Side);
    end else if (image_width_q > gbf_pkg::DimW'(WMax)) begin
      eff_width = gbf_pkg::DimW'(WMax);
    end else begin
      eff_width = image_width_q;
    end
    if (image_height_q < gbf_pkg::DimW'(Side)) begin
      eff_height = gbf_pkg::DimW'(Side);
    end else if (image_height_q > gbf_pkg::CountLimit) begin
      eff_height = gbf_pkg::CountLimit;
    end else begin
      eff_height = image_height_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  logic s1_valid_q, s1_emit_q, s1_fire, in_fire, out_free;
  logic m_valid_q;

  assign out_free      = !m_valid_q || m_axis_tready;
  assign s1_fire       = s1_valid_q && (!s1_emit_q || out_free);
  assign s_axis_tready = !s1_valid_q || s1_fire;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------------------
  // Stage 0: position of the incoming pixel
  // ---------------------------------------------------------------------------
  gbf_pkg::pos_t col_count_q, row_count_q;
  gbf_pkg::pos_t pos_col, pos_row, col_count_d, row_count_d;
  gbf_pkg::dim_t row_tmp, col_inc, row_inc;
  logic          pos_emit, pos_last;

  always_comb begin
    pos_col = s_axis_tuser[0] ? '0 : col_count_q;
    row_tmp = s_axis_tuser[0] ? '0 : {1'b0, row_count_q};
    if ({1'b0, pos_col} >= eff_width) begin
      pos_col = '0;
      row_tmp = row_tmp + gbf_pkg::DimW'(1);
    end
    if (row_tmp >= eff_height) begin
      row_tmp = '0;
    end
    pos_row = row_tmp[gbf_pkg::PosW-1:0];

    // position of the following pixel
    col_inc = {1'b0, pos_col} + gbf_pkg::DimW'(1);
    row_inc = {1'b0, pos_row} + gbf_pkg::DimW'(1);
    if (col_inc >= eff_width) begin
      col_count_d = '0;
      row_count_d = (row_inc >= eff_height) ? '0 : row_inc[gbf_pkg::PosW-1:0];
    end else begin
      col_count_d = col_inc[gbf_pkg::PosW-1:0];
      row_count_d = pos_row;
    end

    pos_emit = (pos_row >= gbf_pkg::PosW'(NLines)) && (pos_col >= gbf_pkg::PosW'(NLines));
    pos_last = ({1'b0, pos_row} == eff_height - gbf_pkg::DimW'(1)) &&
               ({1'b0, pos_col} == eff_width  - gbf_pkg::DimW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_count_q <= '0;
      row_count_q <= '0;
    end else if (in_fire) begin
      col_count_q <= col_count_d;
      row_count_q <= row_count_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1 register: pixel, position, line store read data
  // ---------------------------------------------------------------------------
  gbf_pkg::pixel_t s1_px_q;
  gbf_pkg::pos_t   s1_col_q, s1_orow_q, s1_ocol_q;
  logic            s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_emit_q  <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
      s1_emit_q  <= pos_emit;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
      s1_emit_q  <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_px_q   <= s_axis_tdata;
      s1_col_q  <= pos_col;
      s1_orow_q <= pos_row - gbf_pkg::PosW'(KERNEL_RADIUS);
      s1_ocol_q <= pos_col - gbf_pkg::PosW'(KERNEL_RADIUS);
      s1_last_q <= pos_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Line stores. Line 0 holds the previous row, line NLines-1 the oldest.
  // Read on acceptance, written when the pixel leaves stage 1.
  // ---------------------------------------------------------------------------
  logic [AddrW-1:0] rd_addr, wr_addr;
  gbf_pkg::pixel_t  line_rd    [NLines];
  gbf_pkg::pixel_t  line_wdata [NLines];
  gbf_pkg::pixel_t  line_data  [NLines];
  gbf_pkg::pixel_t  byp_data_q [NLines];
  logic             byp_q;

  assign rd_addr = AddrW'(pos_col);
  assign wr_addr = AddrW'(s1_col_q);

  for (genvar k = 0; k < NLines; k++) begin : g_line
    gbf_pkg::pixel_t mem [MAX_WIDTH];
    gbf_pkg::pixel_t rd_q;

    always_ff @(posedge clk_i) begin
      if (s1_fire) begin
        mem[wr_addr] <= line_wdata[k];
      end
      if (in_fire) begin
        rd_q <= mem[rd_addr];
      end
    end

    assign line_rd[k] = rd_q;
  end

  // same column written and read at one edge: forward the write data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (in_fire) begin
      byp_q <= s1_fire && (s1_col_q == pos_col);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      for (int k = 0; k < NLines; k++) begin
        byp_data_q[k] <= line_wdata[k];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NLines; k++) begin
      line_data[k] = byp_q ? byp_data_q[k] : line_rd[k];
    end
    line_wdata[0] = s1_px_q;
    for (int k = 1; k < NLines; k++) begin
      line_wdata[k] = line_data[k-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Window: shift left, new column enters on the right, oldest row on top
  // ---------------------------------------------------------------------------
  gbf_pkg::pixel_t win_q [Side][Side];
  gbf_pkg::pixel_t win_d [Side][Side];
  gbf_pkg::pixel_t new_col [Side];

  always_comb begin
    for (int k = 0; k < NLines; k++) begin
      new_col[k] = line_data[NLines-1-k];
    end
    new_col[NLines] = s1_px_q;
    for (int r = 0; r < Side; r++) begin
      for (int c = 0; c < Side - 1; c++) begin
        win_d[r][c] = win_q[r][c+1];
      end
      win_d[r][Side-1] = new_col[r];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < Side; r++) begin
        for (int c = 0; c < Side; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else if (s1_fire) begin
      win_q <= win_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Weighted sum of the updated window, one multiplier per tap
  // ---------------------------------------------------------------------------
  logic [SumW-1:0]  sum;
  gbf_pkg::pixel_t  blur_d;

  always_comb begin
    sum = '0;
    for (int r = 0; r < Side; r++) begin
      for (int c = 0; c < Side; c++) begin
        sum = sum + SumW'(gbf_pkg::ProdW'(win_d[r][c]) *
                          gbf_pkg::ProdW'(gbf_pkg::tap_weight(r - int'(KERNEL_RADIUS),
                                                              c - int'(KERNEL_RADIUS),
                                                              weights_q)));
      end
    end
    // drop the 16 fraction bits, saturate at full scale
    if (|sum[SumW-1:gbf_pkg::ProdW]) begin
      blur_d = '1;
    end else begin
      blur_d = sum[gbf_pkg::ProdW-1:gbf_pkg::WeightW];
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  gbf_pkg::pixel_t m_blur_q;
  gbf_pkg::pos_t   m_row_q, m_col_q;
  logic            m_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (s1_fire && s1_emit_q) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_emit_q) begin
      m_blur_q <= blur_d;
      m_row_q  <= s1_orow_q;
      m_col_q  <= s1_ocol_q;
      m_last_q <= s1_last_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = gbf_pkg::OutTdataW'({m_col_q, m_row_q, m_blur_q});
  assign m_axis_tlast  = m_last_q;

endmodule

`default_nettype wire
